// File: rtl/cti_pkg.sv
// Shared types and constants of the colormap tent interpolator.
// Used by cti_ctrl, cti_datapath and colormap_tent_interpolator; depends on nothing.
package cti_pkg;

  // Default depth of each stop table.
  localparam int DEF_MAX_STOPS = 16;

  // Field widths.
  localparam int COORD_W   = 32;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 4;
  localparam int CNT_CFG_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W    = 2;
  localparam int SIDX_W    = 4;

  // Fixed point: ramp sums carry 16 fraction bits.
  localparam int FRAC_W    = 16;
  // Span magnitude and weights fit in one bit more than a coordinate.
  localparam int MAG_W     = COORD_W + 1;
  // At most two stops carry weight, and their weights add up to the span,
  // so a channel numerator is at most 255 times the span.
  localparam int NUM_W     = MAG_W + CH_W;
  // Quotient of a ramp sum: 8 integer bits and 16 fraction bits.
  localparam int QUO_W     = CH_W + FRAC_W;
  localparam int DIV_STEPS = QUO_W;

  // Input modes.
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_X_STOP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_Y_STOP = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_X_SPAN_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_SPAN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SPAN_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SPAN_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_STOP_CNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STOP_CNT  = 3'd5;

  // Reset values of the span registers.
  localparam logic [COORD_W-1:0] SPAN_LOW_RESET  = 32'h0000_0000;
  localparam logic [COORD_W-1:0] SPAN_HIGH_RESET = 32'h0001_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // an input transfer happens this cycle
    logic ramp;      // 0 works on the x ramp, 1 on the y ramp
    logic setup;     // load offset product, span and magnitude; clear walk
    logic walk;      // read the next stop and start its weight
    logic div_load;  // load the dividers from the channel numerators
    logic div_step;  // one quotient bit in every channel
    logic save;      // store the ramp sum of the current ramp
    logic emit;      // form and present the result
  } cti_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic x_used;     // x ramp has at least one stop
    logic y_used;     // y ramp has at least one stop
    logic lone;       // current ramp has exactly one stop
    logic span_zero;  // current ramp has equal span ends
    logic walk_last;  // walk index is at the last stop of the ramp
  } cti_status_t;

endpackage

// File: rtl/colormap_tent_interpolator.sv
// Top level of the colormap tent interpolator: joins controller and datapath.
// Depends on cti_pkg, cti_ctrl and cti_datapath.
//
// Usage: a transfer happens on a clock edge with start high and busy low.
// Stop writes (mode 1 and 2) and the unused mode give no result. A query
// keeps busy high while each ramp with stops is worked: an empty span with
// several stops gives zero, a lone stop gives its color, and otherwise the
// stops are read one by one through the table's single read port, pass the
// weight pipeline and go through the one-bit-per-cycle restoring divider
// that scales each sum by the spacing. With no stops at all the query goes
// straight to the result. The result appears for a single cycle with
// result_valid in the cycle busy falls; it is not held and cannot be
// stalled, so the receiver must take it then. A new transfer may start in
// that same cycle. Configuration writes belong in idle periods.
module colormap_tent_interpolator import cti_pkg::*; #(
  parameter int MAX_STOPS = DEF_MAX_STOPS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  input  logic [MODE_W-1:0]         mode,
  input  logic signed [COORD_W-1:0] x_coord,
  input  logic signed [COORD_W-1:0] y_coord,
  input  logic [SIDX_W-1:0]         stop_index,
  input  logic [CH_W-1:0]           stop_red,
  input  logic [CH_W-1:0]           stop_green,
  input  logic [CH_W-1:0]           stop_blue,
  input  logic [CH_W-1:0]           stop_alpha,
  output logic                      result_valid,
  output logic [CH_W-1:0]           red_out,
  output logic [CH_W-1:0]           green_out,
  output logic [CH_W-1:0]           blue_out,
  output logic [CH_W-1:0]           alpha_out
);

  cti_cmd_t    cmd;
  cti_status_t status;

  // Sequencer.
  cti_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Arithmetic, tables and result register.
  cti_datapath #(
    .MAX_STOPS (MAX_STOPS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .stop_index   (stop_index),
    .stop_red     (stop_red),
    .stop_green   (stop_green),
    .stop_blue    (stop_blue),
    .stop_alpha   (stop_alpha),
    .cmd          (cmd),
    .status       (status),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .alpha_out    (alpha_out),
    .result_valid (result_valid)
  );

  // A transfer that is not a query never makes the block busy.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode != MODE_QUERY)) |=> !busy)
    else $error("busy after a non-query transfer");

  // Busy only starts from a query transfer.
  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ($past(start) && ($past(mode) == MODE_QUERY)))
    else $error("busy rose without a query transfer");

  // A result comes out as the block goes idle.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result while still busy");

  // Two results never come in consecutive cycles.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("back to back results");

endmodule

// File: rtl/cti_ctrl.sv
// Controller of the colormap tent interpolator: sequences setup, stop walk,
// division and result for each ramp. Depends on cti_pkg.
module cti_ctrl import cti_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MODE_W-1:0] mode,
  input  cti_status_t       status,
  output cti_cmd_t          cmd,
  output logic              busy
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SETUP    = 3'd1;
  localparam logic [2:0] S_WALK     = 3'd2;
  localparam logic [2:0] S_DRAIN    = 3'd3;
  localparam logic [2:0] S_DIV_LOAD = 3'd4;
  localparam logic [2:0] S_DIV      = 3'd5;
  localparam logic [2:0] S_SAVE     = 3'd6;
  localparam logic [2:0] S_EMIT     = 3'd7;

  // The weight pipeline is two stages deep behind the memory read.
  localparam logic [4:0] DRAIN_LAST = 5'd1;
  localparam logic [4:0] DIV_LAST   = 5'(DIV_STEPS - 1);

  logic [2:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       ramp, ramp_next;
  logic       accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    ramp_next    = ramp;
    cmd          = '0;
    cmd.accept   = accept;
    cmd.ramp     = ramp;
    case (state)
      S_IDLE: begin
        if (accept && (mode == MODE_QUERY)) begin
          if (!status.x_used && !status.y_used) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_SETUP;
            ramp_next  = !status.x_used;
          end
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        cnt_next  = '0;
        if (!status.lone && status.span_zero) begin
          state_next = S_SAVE;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (cnt == DRAIN_LAST) begin
          cnt_next   = '0;
          state_next = status.lone ? S_SAVE : S_DIV_LOAD;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = S_SAVE;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_SAVE: begin
        cmd.save = 1'b1;
        if (!ramp && status.y_used) begin
          ramp_next  = 1'b1;
          state_next = S_SETUP;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ramp  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ramp  <= ramp_next;
    end
  end

endmodule

// File: rtl/cti_datapath.sv
// Datapath of the colormap tent interpolator: configuration registers, stop
// tables, tent weight pipeline, four restoring dividers and result register.
// Depends on cti_pkg; driven by cti_ctrl.
module cti_datapath import cti_pkg::*; #(
  parameter int MAX_STOPS = DEF_MAX_STOPS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_W-1:0]          cfg_data,
  input  logic [MODE_W-1:0]           mode,
  input  logic signed [COORD_W-1:0]   x_coord,
  input  logic signed [COORD_W-1:0]   y_coord,
  input  logic [SIDX_W-1:0]           stop_index,
  input  logic [CH_W-1:0]             stop_red,
  input  logic [CH_W-1:0]             stop_green,
  input  logic [CH_W-1:0]             stop_blue,
  input  logic [CH_W-1:0]             stop_alpha,
  input  cti_cmd_t                    cmd,
  output cti_status_t                 status,
  output logic [CH_W-1:0]             red_out,
  output logic [CH_W-1:0]             green_out,
  output logic [CH_W-1:0]             blue_out,
  output logic [CH_W-1:0]             alpha_out,
  output logic                        result_valid
);

  localparam int CNT_W  = $clog2(MAX_STOPS + 1);
  localparam int IDX_W  = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int T_W    = MAG_W + CNT_W + 1;
  localparam int D_W    = T_W + 1;
  localparam int WORD_W = CH_W * NUM_CH;

  // Configuration registers.
  logic signed [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
  logic [CNT_CFG_W-1:0]      x_cnt, y_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_lo  <= SPAN_LOW_RESET;
      x_hi  <= SPAN_HIGH_RESET;
      y_lo  <= SPAN_LOW_RESET;
      y_hi  <= SPAN_HIGH_RESET;
      x_cnt <= '0;
      y_cnt <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_X_SPAN_LOW:  x_lo  <= cfg_data;
        REG_X_SPAN_HIGH: x_hi  <= cfg_data;
        REG_Y_SPAN_LOW:  y_lo  <= cfg_data;
        REG_Y_SPAN_HIGH: y_hi  <= cfg_data;
        REG_X_STOP_CNT:  x_cnt <= cfg_data[CNT_CFG_W-1:0];
        REG_Y_STOP_CNT:  y_cnt <= cfg_data[CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Stop counts clamped to the table depth, and the current ramp's view.
  logic [CNT_W-1:0]          x_n, y_n, cur_n, nm1;
  logic signed [COORD_W-1:0] cur_lo, cur_hi;
  logic [IDX_W-1:0]          widx;

  assign x_n    = (32'(x_cnt) > MAX_STOPS) ? CNT_W'(MAX_STOPS) : CNT_W'(x_cnt);
  assign y_n    = (32'(y_cnt) > MAX_STOPS) ? CNT_W'(MAX_STOPS) : CNT_W'(y_cnt);
  assign cur_n  = cmd.ramp ? y_n : x_n;
  assign cur_lo = cmd.ramp ? y_lo : x_lo;
  assign cur_hi = cmd.ramp ? y_hi : x_hi;
  assign nm1    = cur_n - CNT_W'(1);

  assign status.x_used    = (x_n != '0);
  assign status.y_used    = (y_n != '0);
  assign status.lone      = (cur_n == CNT_W'(1));
  assign status.span_zero = (cur_hi == cur_lo);
  assign status.walk_last = (CNT_W'(widx) == nm1);

  // Stop tables; a stop write lands on the transfer cycle.
  logic [WORD_W-1:0] x_mem [MAX_STOPS];
  logic [WORD_W-1:0] y_mem [MAX_STOPS];
  logic              idx_ok;
  logic [WORD_W-1:0] stop_word;

  assign idx_ok    = (32'(stop_index) < MAX_STOPS);
  assign stop_word = {stop_alpha, stop_blue, stop_green, stop_red};

  always_ff @(posedge clk) begin
    if (cmd.accept && idx_ok && (mode == MODE_X_STOP)) begin
      x_mem[IDX_W'(stop_index)] <= stop_word;
    end
    if (cmd.accept && idx_ok && (mode == MODE_Y_STOP)) begin
      y_mem[IDX_W'(stop_index)] <= stop_word;
    end
  end

  // Query offsets from the low span ends, taken at the transfer.
  logic signed [MAG_W-1:0] off_x, off_y, cur_off;

  always_ff @(posedge clk) begin
    if (cmd.accept && (mode == MODE_QUERY)) begin
      off_x <= {x_coord[COORD_W-1], x_coord} - {x_lo[COORD_W-1], x_lo};
      off_y <= {y_coord[COORD_W-1], y_coord} - {y_lo[COORD_W-1], y_lo};
    end
  end

  assign cur_off = cmd.ramp ? off_y : off_x;

  // Ramp setup: scaled offset t, span, and its magnitude.
  logic signed [MAG_W-1:0] span_c, span_r;
  logic signed [T_W-1:0]   t_prod, t_r, pos;
  logic [MAG_W-1:0]        mag;

  assign span_c = {cur_hi[COORD_W-1], cur_hi} - {cur_lo[COORD_W-1], cur_lo};
  assign t_prod = T_W'(cur_off) * T_W'($signed({1'b0, nm1}));

  // Stage one of the walk: stop read and distance from the stop position.
  logic                    v1, v2;
  logic signed [D_W-1:0]   diff1;
  logic [WORD_W-1:0]       data1, data2;
  logic [D_W-1:0]          dabs;
  logic [MAG_W-1:0]        w2;
  logic [NUM_W-1:0]        num   [NUM_CH];
  logic [NUM_W-1:0]        wprod [NUM_CH];

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      t_r    <= t_prod;
      span_r <= span_c;
      mag    <= span_c[MAG_W-1] ? MAG_W'(-span_c) : MAG_W'(span_c);
      pos    <= '0;
      widx   <= '0;
    end else if (cmd.walk) begin
      diff1 <= {t_r[T_W-1], t_r} - {pos[T_W-1], pos};
      data1 <= cmd.ramp ? y_mem[widx] : x_mem[widx];
      pos   <= pos + {{(T_W - MAG_W){span_r[MAG_W-1]}}, span_r};
      widx  <= widx + IDX_W'(1);
    end
  end

  // Stage two: tent weight, kept only inside one spacing of the stop.
  assign dabs = diff1[D_W-1] ? D_W'(-diff1) : D_W'(diff1);

  always_ff @(posedge clk) begin
    w2    <= (dabs < D_W'(mag)) ? (mag - dabs[MAG_W-1:0]) : '0;
    data2 <= data1;
  end

  // Stage three: weighted channel sums.
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      wprod[k] = NUM_W'(w2) * NUM_W'(data2[k*CH_W +: CH_W]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_CH; k++) begin
      if (cmd.setup) begin
        num[k] <= '0;
      end else if (v2) begin
        num[k] <= num[k] + wprod[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.walk;
      v2 <= v1;
    end
  end

  // Restoring dividers, one per channel, sharing the span magnitude.
  logic [MAG_W-1:0] rem   [NUM_CH];
  logic [QUO_W-1:0] lo_sh [NUM_CH];
  logic [QUO_W-1:0] quo   [NUM_CH];
  logic [MAG_W:0]   trial [NUM_CH];
  logic [MAG_W:0]   tdiff [NUM_CH];
  logic             ge    [NUM_CH];

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      trial[k] = {rem[k], lo_sh[k][QUO_W-1]};
      tdiff[k] = trial[k] - {1'b0, mag};
      ge[k]    = (trial[k] >= {1'b0, mag});
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_CH; k++) begin
      if (cmd.div_load) begin
        rem[k]   <= num[k][NUM_W-1 -: MAG_W];
        lo_sh[k] <= {num[k][QUO_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
        quo[k]   <= '0;
      end else if (cmd.div_step) begin
        rem[k]   <= ge[k] ? tdiff[k][MAG_W-1:0] : trial[k][MAG_W-1:0];
        lo_sh[k] <= lo_sh[k] << 1;
        quo[k]   <= {quo[k][QUO_W-2:0], ge[k]};
      end
    end
  end

  // Ramp sums: divided, lone stop color, or zero for an empty span.
  logic [QUO_W-1:0] sx [NUM_CH];
  logic [QUO_W-1:0] sy [NUM_CH];
  logic [QUO_W-1:0] s_new [NUM_CH];

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      if (status.lone) begin
        s_new[k] = {data2[k*CH_W +: CH_W], {FRAC_W{1'b0}}};
      end else if (status.span_zero) begin
        s_new[k] = '0;
      end else begin
        s_new[k] = quo[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_CH; k++) begin
      if (cmd.save && !cmd.ramp) begin
        sx[k] <= s_new[k];
      end
      if (cmd.save && cmd.ramp) begin
        sy[k] <= s_new[k];
      end
    end
  end

  // Result: average of both ramps, one ramp alone, or opaque white.
  // A ramp sum stays below 256 in its integer part, so the top bits
  // already saturate at 255.
  logic [CH_W-1:0]  ch_c  [NUM_CH];
  logic [QUO_W:0]   both  [NUM_CH];

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      both[k] = {1'b0, sx[k]} + {1'b0, sy[k]};
      if (!status.x_used && !status.y_used) begin
        ch_c[k] = '1;
      end else if (status.x_used && status.y_used) begin
        ch_c[k] = both[k][QUO_W -: CH_W];
      end else if (status.x_used) begin
        ch_c[k] = sx[k][QUO_W-1 -: CH_W];
      end else begin
        ch_c[k] = sy[k][QUO_W-1 -: CH_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      red_out   <= ch_c[0];
      green_out <= ch_c[1];
      blue_out  <= ch_c[2];
      alpha_out <= ch_c[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for colormap_tent_interpolator: stop tables, span
// registers, lone-stop, reversed, empty and oversized ramps, then random traffic.
// Depends on cti_pkg and the RTL of colormap_tent_interpolator only.
module tb import cti_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // The block leaves mode 3 unused.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int REPORT_LIMIT = 10;

  // One interpolated color, laid out like a stop word: red in the low byte.
  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } color_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;
  logic [MODE_W-1:0]    mode = MODE_QUERY;
  logic [COORD_W-1:0]   x_coord = '0;
  logic [COORD_W-1:0]   y_coord = '0;
  logic [SIDX_W-1:0]    stop_index = '0;
  logic [CH_W-1:0]      stop_red = '0;
  logic [CH_W-1:0]      stop_green = '0;
  logic [CH_W-1:0]      stop_blue = '0;
  logic [CH_W-1:0]      stop_alpha = '0;
  logic                 result_valid;
  logic [CH_W-1:0]      red_out;
  logic [CH_W-1:0]      green_out;
  logic [CH_W-1:0]      blue_out;
  logic [CH_W-1:0]      alpha_out;

  colormap_tent_interpolator uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .stop_index   (stop_index),
    .stop_red     (stop_red),
    .stop_green   (stop_green),
    .stop_blue    (stop_blue),
    .stop_alpha   (stop_alpha),
    .result_valid (result_valid),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .alpha_out    (alpha_out)
  );

  // Shadow copy of the block's registers and stop tables.
  longint      x_lo_pos = 0;
  longint      x_hi_pos = 65536;
  longint      y_lo_pos = 0;
  longint      y_hi_pos = 65536;
  int          x_ramp_len = 0;
  int          y_ramp_len = 0;
  logic [31:0] x_colors [DEF_MAX_STOPS];
  logic [31:0] y_colors [DEF_MAX_STOPS];

  color_t pending_colors [$];
  int     mismatch_count = 0;
  int     results_seen = 0;
  int     queries_sent = 0;
  int     stop_writes_sent = 0;
  int     settings_applied = 0;
  int     cycle_count = 0;
  int     idle_pct = 0;
  bit     start_held = 1'b0;

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint to_pos(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // Tent-weighted sum of one channel over one ramp, with 16 fraction bits.
  function automatic longint unsigned ramp_channel(input bit on_y, input int n,
      input longint lo, input longint hi, input longint p, input int ch);
    longint          span, offset, diff;
    longint unsigned mag, delta, weight, acc, chan;
    logic [31:0]     word;
    int              i;
    acc = 0;
    if (n == 1) begin
      word = on_y ? y_colors[0] : x_colors[0];
      chan = 64'(word[8*ch +: 8]);
      return chan << 16;
    end
    span = hi - lo;
    mag = (span < 0) ? -span : span;
    if (mag == 0) return 0;
    offset = (p - lo) * (n - 1);
    for (i = 0; i < n; i++) begin
      diff = offset - i * span;
      delta = (diff < 0) ? -diff : diff;
      if (delta < mag) begin
        weight = mag - delta;
        word = on_y ? y_colors[i] : x_colors[i];
        chan = 64'(word[8*ch +: 8]);
        acc += weight * chan;
      end
    end
    return (acc << 16) / mag;
  endfunction

  // Color the block should give for a query point.
  function automatic color_t predict_color(input logic [31:0] px, input logic [31:0] py);
    int              nx, ny, ch;
    longint unsigned sx, sy, v;
    color_t          c;
    nx = (x_ramp_len > DEF_MAX_STOPS) ? DEF_MAX_STOPS : x_ramp_len;
    ny = (y_ramp_len > DEF_MAX_STOPS) ? DEF_MAX_STOPS : y_ramp_len;
    c = '1;
    if (nx == 0 && ny == 0) return c;
    for (ch = 0; ch < NUM_CH; ch++) begin
      sx = (nx > 0) ? ramp_channel(1'b0, nx, x_lo_pos, x_hi_pos, to_pos(px), ch) : 0;
      sy = (ny > 0) ? ramp_channel(1'b1, ny, y_lo_pos, y_hi_pos, to_pos(py), ch) : 0;
      if (nx > 0 && ny > 0) v = (sx + sy) >> 17;
      else if (nx > 0) v = sx >> 16;
      else v = sy >> 16;
      if (v > 255) v = 255;
      c[8*ch +: 8] = v[7:0];
    end
    return c;
  endfunction

  // Update the shadow state for one accepted transfer.
  task automatic record_transfer(input logic [MODE_W-1:0] m, input logic [31:0] px,
      input logic [31:0] py, input logic [SIDX_W-1:0] idx, input logic [31:0] color);
    case (m)
      MODE_X_STOP: begin
        x_colors[idx] = color;
        stop_writes_sent++;
      end
      MODE_Y_STOP: begin
        y_colors[idx] = color;
        stop_writes_sent++;
      end
      MODE_QUERY: begin
        pending_colors.insert(pending_colors.size(), predict_color(px, py));
        queries_sent++;
      end
      default: ;
    endcase
  endtask

  // Drive one item after a random number of idle cycles, and wait for its
  // transfer. Start stays high afterwards so back-to-back items need no
  // new rising edge on start.
  task automatic send_item(input logic [MODE_W-1:0] m, input logic [31:0] px,
      input logic [31:0] py, input logic [SIDX_W-1:0] idx, input logic [31:0] color);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      if (start_held) start <= 1'b0;
      start_held = 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    start_held = 1'b1;
    mode <= m;
    x_coord <= px;
    y_coord <= py;
    stop_index <= idx;
    stop_red <= color[7:0];
    stop_green <= color[15:8];
    stop_blue <= color[23:16];
    stop_alpha <= color[31:24];
    do @(posedge clk); while (busy);
    record_transfer(m, px, py, idx, color);
  endtask

  // Unused fields carry random values.
  task automatic send_query(input logic [31:0] px, input logic [31:0] py);
    send_item(MODE_QUERY, px, py, SIDX_W'($urandom), $urandom);
  endtask

  task automatic send_stop(input logic [MODE_W-1:0] m, input logic [SIDX_W-1:0] idx,
      input logic [31:0] color);
    send_item(m, $urandom, $urandom, idx, color);
  endtask

  // Let the block drain: every result in, busy low, then a few quiet cycles.
  task automatic wait_idle();
    if (start_held) start <= 1'b0;
    start_held = 1'b0;
    while (pending_colors.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_X_SPAN_LOW:  x_lo_pos = to_pos(data);
      REG_X_SPAN_HIGH: x_hi_pos = to_pos(data);
      REG_Y_SPAN_LOW:  y_lo_pos = to_pos(data);
      REG_Y_SPAN_HIGH: y_hi_pos = to_pos(data);
      REG_X_STOP_CNT:  x_ramp_len = int'(data[CNT_CFG_W-1:0]);
      REG_Y_STOP_CNT:  y_ramp_len = int'(data[CNT_CFG_W-1:0]);
      default: ;
    endcase
  endtask

  // Write all six registers while the block is idle.
  task automatic apply_settings(input logic [31:0] xl, input logic [31:0] xh,
      input logic [31:0] yl, input logic [31:0] yh, input logic [31:0] xn,
      input logic [31:0] yn);
    wait_idle();
    write_reg(REG_X_SPAN_LOW, xl);
    write_reg(REG_X_SPAN_HIGH, xh);
    write_reg(REG_Y_SPAN_LOW, yl);
    write_reg(REG_Y_SPAN_HIGH, yh);
    write_reg(REG_X_STOP_CNT, xn);
    write_reg(REG_Y_STOP_CNT, yn);
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  // Result checker: each strobe is matched against the oldest expectation.
  task automatic check_field(input string name, input logic [7:0] want,
      input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                 name, results_seen, want, got);
    end
  endtask

  always @(posedge clk) begin
    color_t want;
    if (!rst && result_valid === 1'b1) begin
      results_seen++;
      if (pending_colors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("Unexpected result %0d: r=%0d g=%0d b=%0d a=%0d", results_seen,
                   red_out, green_out, blue_out, alpha_out);
      end else begin
        want = pending_colors.pop_front();
        check_field("red", want.red, red_out);
        check_field("green", want.green, green_out);
        check_field("blue", want.blue, blue_out);
        check_field("alpha", want.alpha, alpha_out);
      end
    end
  end

  // Span choices: full range either way, empty, small, random, and spans that
  // divide evenly so stop positions land on exact coordinates.
  task automatic pick_span(output logic [31:0] lo, output logic [31:0] hi);
    int     sel;
    longint base, width, top;
    sel = $urandom_range(0, 5);
    base = $urandom_range(0, 8388608);
    base = base - 4194304;
    width = $urandom_range(1, 1048576);
    if (sel > 3) width = 720720 * $urandom_range(1, 8);
    if ($urandom_range(0, 2) == 0) width = -width;
    top = base + width;
    lo = base[31:0];
    hi = top[31:0];
    case (sel)
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
        if ($urandom_range(0, 1)) begin
          lo = 32'h7FFF_FFFF;
          hi = 32'h8000_0000;
        end
      end
      1: begin
        lo = $urandom;
        hi = lo;
      end
      3: begin
        lo = $urandom;
        hi = $urandom;
      end
      default: ;
    endcase
  endtask

  // Stop count, sometimes beyond the table depth, with junk in unused bits.
  function automatic logic [31:0] pick_count();
    logic [31:0] v;
    int          n;
    case ($urandom_range(0, 9))
      0: n = 0;
      1: n = 1;
      2: n = 2;
      3: n = DEF_MAX_STOPS;
      4: n = $urandom_range(DEF_MAX_STOPS + 1, 31);
      default: n = $urandom_range(2, DEF_MAX_STOPS);
    endcase
    v = $urandom;
    if ($urandom_range(0, 1)) v = '0;
    v[CNT_CFG_W-1:0] = CNT_CFG_W'(n);
    return v;
  endfunction

  // Query coordinates: mostly inside the span or on a stop, some anywhere.
  function automatic logic [31:0] pick_coord(input longint lo, input longint hi,
      input int n);
    longint span, p, k, frac;
    int     sel;
    span = hi - lo;
    sel = $urandom_range(0, 19);
    frac = $urandom_range(0, 69999);
    k = (n > 1) ? $urandom_range(0, n - 1) : 0;
    if (sel < 3) begin
      p = $urandom;
    end else if (sel < 8 && n > 1) begin
      p = lo + span * k / (n - 1);
      if (sel == 7) begin
        k = $urandom_range(0, 2);
        p = p + k - 1;
      end
    end else begin
      p = lo + span * (frac - 2000) / 66000;
    end
    return p[31:0];
  endfunction

  // Every stop of both tables gets a color before any query reads it.
  task automatic preload_stops();
    int i;
    for (i = 0; i < DEF_MAX_STOPS; i++) begin
      send_stop(MODE_X_STOP, SIDX_W'(i),
                (i == 0) ? 32'hFFFF_FFFF : (i == 15) ? 32'h0 : $urandom);
      send_stop(MODE_Y_STOP, SIDX_W'(i),
                (i == 0) ? 32'h0 : (i == 15) ? 32'hFFFF_FFFF : $urandom);
    end
  endtask

  // With no stops anywhere a query gives opaque white; mode 3 gives nothing.
  task automatic test_no_stops();
    send_query(32'h0, 32'h0);
    send_query(32'h8000_0000, 32'h7FFF_FFFF);
    send_item(MODE_UNUSED, $urandom, $urandom, SIDX_W'($urandom), $urandom);
  endtask

  // Two x stops on the reset span, sampled at the ends, midpoint and outside.
  task automatic test_default_span();
    apply_settings(SPAN_LOW_RESET, SPAN_HIGH_RESET, SPAN_LOW_RESET, SPAN_HIGH_RESET,
                   32'd2, 32'd0);
    send_query(32'h0000_0000, $urandom);
    send_query(32'h0000_8000, $urandom);
    send_query(32'h0001_0000, $urandom);
    send_query(32'hFFFF_0000, $urandom);
    send_query(32'h0002_0000, $urandom);
  endtask

  // A lone stop gives its own color, alone or averaged with the other ramp.
  task automatic test_lone_stop();
    apply_settings(32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'd1, 32'd0);
    send_query($urandom, $urandom);
    apply_settings(32'h0, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'd1, 32'd3);
    send_query($urandom, 32'h0001_0000);
    send_query($urandom, 32'h0001_8000);
    apply_settings(32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'd0, 32'd1);
    send_query($urandom, $urandom);
    apply_settings(32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'd1, 32'd1);
    send_query($urandom, $urandom);
  endtask

  // High below low: stops run downward on both ramps.
  task automatic test_reversed_span();
    apply_settings(32'h0004_0000, 32'hFFFC_0000, 32'h0, 32'hFFFF_0000, 32'd5, 32'd2);
    send_query(32'h0004_0000, 32'h0);
    send_query(32'h0, 32'hFFFF_8000);
    send_query(32'hFFFC_0000, 32'hFFFF_0000);
    send_query(32'h0000_8000, 32'h0000_4000);
  endtask

  // Equal span ends with several stops: that ramp contributes zero.
  task automatic test_empty_span();
    apply_settings(32'h0012_3456, 32'h0012_3456, 32'h0, 32'h0001_0000, 32'd3, 32'd0);
    send_query(32'h0012_3456, $urandom);
    apply_settings(32'h0012_3456, 32'h0012_3456, 32'h0, 32'h0001_0000, 32'd3, 32'd2);
    send_query(32'h0012_3456, 32'h0000_4000);
  endtask

  // Counts beyond the table depth act as full tables, on full-range spans.
  task automatic test_count_overflow();
    apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'd31, 32'd17);
    send_query(32'h8000_0000, 32'h7FFF_FFFF);
    send_query(32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h0, 32'h0);
    send_query(32'h1234_5678, 32'hEDCB_A988);
  endtask

  // One register setting followed by random traffic, mostly queries.
  task automatic run_random_setting(input int idle, input int items);
    logic [31:0] xl, xh, yl, yh, xn, yn;
    int          sent, pick, nx, ny;
    pick_span(xl, xh);
    pick_span(yl, yh);
    xn = pick_count();
    yn = pick_count();
    apply_settings(xl, xh, yl, yh, xn, yn);
    nx = (x_ramp_len > DEF_MAX_STOPS) ? DEF_MAX_STOPS : x_ramp_len;
    ny = (y_ramp_len > DEF_MAX_STOPS) ? DEF_MAX_STOPS : y_ramp_len;
    idle_pct = idle;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_item(MODE_UNUSED, $urandom, $urandom, SIDX_W'($urandom), $urandom);
      end else begin
        sent++;
        if (pick < 20) send_stop(MODE_X_STOP, SIDX_W'($urandom), $urandom);
        else if (pick < 35) send_stop(MODE_Y_STOP, SIDX_W'($urandom), $urandom);
        else send_query(pick_coord(x_lo_pos, x_hi_pos, nx),
                        pick_coord(y_lo_pos, y_hi_pos, ny));
      end
    end
    idle_pct = 0;
  endtask

  // Random part: settings cycle through no idling, heavy and light sender gaps.
  task automatic test_random_traffic();
    int s;
    for (s = 0; s < 12; s++) begin
      case (s % 3)
        0: run_random_setting(0, 75);
        1: run_random_setting(71, 75);
        default: run_random_setting(28, 75);
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_stops();
    preload_stops();
    test_default_span();
    test_lone_stop();
    test_reversed_span();
    test_empty_span();
    test_count_overflow();
    test_random_traffic();

    // Drain, then watch a while longer for stray results.
    wait_idle();
    repeat (100) @(posedge clk);
    if (pending_colors.size() != 0) begin
      mismatch_count += pending_colors.size();
      $display("%0d expected results never arrived", pending_colors.size());
    end

    $display("Ran %0d queries and %0d stop writes over %0d register settings;",
             queries_sent, stop_writes_sent, settings_applied);
    $display("checked %0d results, %0d mismatches, in %0d cycles.",
             results_seen, mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
